@@ design/spcp_pkg.sv @@
package spcp_pkg;

   localparam int WinDepth = 9;
   localparam int DigitCount = 8;

   localparam logic [7:0] CHAR_BANG = 8'h21;
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic signed [8:0] DIGIT_BIAS = 9'sd48;

   localparam logic [3:0] SLOT_NONE = 4'd12;
   localparam int SlotCount = 12;

   typedef logic [7:0] byte_type;
   typedef logic [3:0] slot_type;
   typedef logic signed [28:0] value_type;

   typedef struct packed {
      slot_type slot;
      value_type value;
      logic ok;
   } result_type;

   // Key pairs in slot order: right loop, left loop, angle loop.
   localparam logic [15:0] SLOT_KEYS [SlotCount] = '{
      {8'h4B, 8'h31}, {8'h4B, 8'h32}, {8'h4B, 8'h33}, {8'h52, 8'h74},
      {8'h50, 8'h32}, {8'h49, 8'h32}, {8'h44, 8'h32}, {8'h4C, 8'h74},
      {8'h50, 8'h31}, {8'h49, 8'h31}, {8'h44, 8'h31}, {8'h4F, 8'h74}
   };

   function automatic slot_type lookup_slot(input byte_type key_a, input byte_type key_b);
      slot_type slot;
      slot = SLOT_NONE;
      // Scan from the top so the lowest matching slot wins.
      for (int s = SlotCount - 1; s >= 0; s--) begin
         if (SLOT_KEYS[s] == {key_a, key_b}) begin
            slot = 4'(s);
         end
      end
      return slot;
   endfunction

   function automatic int pow10(input int e);
      int p;
      p = 1;
      for (int i = 0; i < e; i++) begin
         p = p * 10;
      end
      return p;
   endfunction

endpackage

@@ design/spcp_decode.sv @@
module spcp_decode (
   input spcp_pkg::byte_type window [spcp_pkg::WinDepth],
   input logic [7:0] count,
   input spcp_pkg::byte_type key_a,
   input spcp_pkg::byte_type key_b,
   output spcp_pkg::result_type result
);
   import spcp_pkg::*;

   logic neg;
   logic [7:0] n;
   logic ok;
   logic [2:0] sel;
   logic signed [8:0] dig [DigitCount];
   value_type sums [5];
   value_type magnitude;

   always_comb begin
      neg = (count != 8'd0) && (window[0] == CHAR_MINUS);
      n = count - {7'd0, neg};
      ok = (n >= 8'd4) && (n <= 8'd8);
      sel = 3'(n - 8'd4);
      for (int k = 0; k < DigitCount; k++) begin
         dig[k] = $signed({1'b0, (neg ? window[k + 1] : window[k])}) - DIGIT_BIAS;
      end
   end

   // One constant-weight sum per field length; the point character is skipped.
   always_comb begin
      value_type acc;
      int e;
      for (int nn = 4; nn <= 8; nn++) begin
         acc = '0;
         for (int k = 0; k < DigitCount; k++) begin
            e = nn - 1 - k - ((k < nn - 3) ? 1 : 0);
            if (k < nn && k != nn - 3) begin
               acc = acc + value_type'(dig[k]) * value_type'(pow10(e));
            end
         end
         sums[nn - 4] = acc;
      end
   end

   always_comb begin
      magnitude = '0;
      if (ok) begin
         case (sel)
            3'd0: magnitude = sums[0];
            3'd1: magnitude = sums[1];
            3'd2: magnitude = sums[2];
            3'd3: magnitude = sums[3];
            3'd4: magnitude = sums[4];
            default: magnitude = '0;
         endcase
      end
      result.slot = lookup_slot(key_a, key_b);
      result.value = neg ? -magnitude : magnitude;
      result.ok = ok;
   end

endmodule

@@ design/serial_param_command_parser.sv @@
// Serial parameter command parser.
// The request channel (req_) carries one received serial byte per transfer.
// Bytes are framed into commands such as K1=12.34! ending at '!'. The first
// two bytes form the key, the bytes after the last '=' form the number field.
// The response channel (rsp_) carries one result per '!' byte that is not
// dropped at the frame limit: the parameter slot (12 for an unknown key), the
// value in signed hundredths and a flag that is set when the number field held
// 4 to 8 characters after an optional '-'. Other bytes give no response. A
// frame that reaches FRAME_LIMIT bytes is dropped together with the byte that
// arrives next. A result is in the output register the cycle after its '!' is
// accepted. One byte is taken every cycle unless the receiver stalls; the
// decode is a single pass of constant-weight sums between the frame registers
// and the output register. When the receiver stalls, the output register holds
// its result and req_tready drops until it is taken. Reset clears the frame and
// empties the output register.
module serial_param_command_parser #(
   parameter int unsigned FRAME_LIMIT = 128
) (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   output logic req_tready,
   input logic [7:0] req_tdata,   // [7:0] rx_byte
   output logic rsp_tvalid,
   input logic rsp_tready,
   output logic [39:0] rsp_tdata  // [3:0] param_slot, [32:4] value_hundredths, [33] length_ok
);
   import spcp_pkg::*;

   logic [7:0] pos_ff, pos_in;
   byte_type key_a_ff, key_a_in;
   byte_type key_b_ff, key_b_in;
   logic [7:0] count_ff, count_in;
   byte_type window_ff [WinDepth];
   logic rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;

   logic accept;
   logic overflow;
   logic is_bang;
   logic is_equals;
   logic win_we;
   byte_type key_a_now;
   byte_type key_b_now;
   result_type result;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept = req_tvalid && req_tready;
   assign overflow = pos_ff >= 8'(FRAME_LIMIT);
   assign is_bang = req_tdata == CHAR_BANG;
   assign is_equals = req_tdata == CHAR_EQUALS;
   assign key_a_now = (pos_ff == 8'd0) ? req_tdata : key_a_ff;
   assign key_b_now = (pos_ff == 8'd1) ? req_tdata : key_b_ff;
   assign win_we = accept && !overflow && !is_bang && !is_equals && (count_ff < 8'(WinDepth));

   spcp_decode u_decode (
      .window(window_ff),
      .count(count_ff),
      .key_a(key_a_now),
      .key_b(key_b_now),
      .result(result)
   );

   always_comb begin
      pos_in = pos_ff;
      key_a_in = key_a_ff;
      key_b_in = key_b_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      if (accept) begin
         if (overflow || is_bang) begin
            // drop the frame; a '!' also emits its result unless the frame overflowed
            pos_in = '0;
            key_a_in = '0;
            key_b_in = '0;
            count_in = '0;
            if (!overflow) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = {6'd0, result.ok, result.value, result.slot};
            end
         end else begin
            pos_in = pos_ff + 8'd1;
            key_a_in = key_a_now;
            key_b_in = key_b_now;
            if (is_equals) begin
               count_in = '0;
            end else if (count_ff != 8'd255) begin
               count_in = count_ff + 8'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         key_a_ff <= '0;
         key_b_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         key_a_ff <= key_a_in;
         key_b_ff <= key_b_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (win_we) begin
         window_ff[count_ff[3:0]] <= req_tdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

@@ design/spcp_checker.sv @@
module spcp_checker (
   input logic clock,
   input logic reset,
   input logic req_tvalid,
   input logic req_tready,
   input logic [7:0] req_tdata,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [39:0] rsp_tdata
);
   import spcp_pkg::*;

   // A new response is only ever created by an accepted '!' in the cycle before.
   a_rsp_from_bang: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid && !rsp_tready)) |->
         $past(req_tvalid && req_tready && req_tdata == CHAR_BANG))
      else $error("response without an accepted terminator");

   a_bad_length_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[33]) |-> (rsp_tdata[32:4] == 29'd0))
      else $error("rejected length with nonzero value");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] <= SLOT_NONE && rsp_tdata[39:34] == 6'd0))
      else $error("slot out of range or padding set");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("request stalled while output can move");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled response changed");

endmodule

bind serial_param_command_parser spcp_checker u_spcp_checker (
   .clock(clock),
   .reset(reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .req_tdata(req_tdata),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata)
);

@@ verif/serial_param_command_parser_test.sv @@
`timescale 1ns / 1ps

module serial_param_command_parser_test;
   import spcp_pkg::*;

   localparam int unsigned FrameLimit = 128;
   localparam int RequestTarget = 1150;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;

   // Tracks the command framing and holds the responses still owed by the parser.
   class command_scoreboard;
      int unsigned frame_limit;
      int unsigned frame_pos;
      int unsigned field_count;
      byte_type key_a;
      byte_type key_b;
      byte_type window [WinDepth];
      result_type pending_q [$];
      int errors;
      logic [15:0] slot_names [SlotCount] = '{
         "K1", "K2", "K3", "Rt", "P2", "I2", "D2", "Lt", "P1", "I1", "D1", "Ot"
      };

      function new(int unsigned limit);
         frame_limit = limit;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         frame_pos = 0;
         field_count = 0;
         key_a = '0;
         key_b = '0;
         foreach (window[i]) window[i] = '0;
      endfunction

      function slot_type slot_of(byte_type a, byte_type b);
         for (int s = 0; s < SlotCount; s++) begin
            if (slot_names[s] == {a, b}) begin
               return slot_type'(s);
            end
         end
         return SLOT_NONE;
      endfunction

      // Decode the number field: the char at n-3 is the point, others are code minus 48.
      function void close_frame();
         int unsigned off;
         int unsigned n;
         int acc;
         result_type r;
         off = (field_count > 0 && window[0] == CHAR_MINUS) ? 1 : 0;
         n = field_count - off;
         acc = 0;
         r.ok = (n >= 4 && n <= 8);
         if (r.ok) begin
            for (int k = 0; k < n; k++) begin
               if (k != n - 3) begin
                  acc = acc * 10 + (int'(window[(off + k) % WinDepth]) - int'(DIGIT_BIAS));
               end
            end
         end
         if (off != 0) begin
            acc = -acc;
         end
         r.slot = slot_of(key_a, key_b);
         r.value = acc[28:0];
         pending_q.push_back(r);
         clear_frame();
      endfunction

      function void note_request(byte_type b);
         // A full frame swallows the arriving byte and starts over.
         if (frame_pos >= frame_limit) begin
            clear_frame();
            return;
         end
         if (frame_pos == 0) begin
            key_a = b;
         end else if (frame_pos == 1) begin
            key_b = b;
         end
         frame_pos++;
         if (b == CHAR_BANG) begin
            close_frame();
         end else if (b == CHAR_EQUALS) begin
            field_count = 0;
         end else begin
            if (field_count < WinDepth) begin
               window[field_count] = b;
            end
            if (field_count < 255) begin
               field_count++;
            end
         end
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_response(logic [39:0] data);
         result_type want;
         slot_type got_slot;
         value_type got_value;
         logic got_ok;
         got_slot = data[3:0];
         got_value = data[32:4];
         got_ok = data[33];
         if (pending_q.size() == 0) begin
            report($sformatf("unexpected response slot=%0d value=%0d ok=%0b",
                             got_slot, got_value, got_ok));
            return;
         end
         want = pending_q.pop_front();
         if (got_slot !== want.slot) begin
            report($sformatf("param_slot got %0d want %0d", got_slot, want.slot));
         end
         if (got_value !== want.value) begin
            report($sformatf("value_hundredths got %0d want %0d", got_value, want.value));
         end
         if (got_ok !== want.ok) begin
            report($sformatf("length_ok got %0b want %0b", got_ok, want.ok));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [39:0] rsp_tdata;

   command_scoreboard sb = new(FrameLimit);
   byte_type frame_q [$];
   int requests_sent;
   bit steady_send;
   bit steady_recv;
   int unsigned recv_hold;

   serial_param_command_parser #(
      .FRAME_LIMIT(FrameLimit)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic byte_type any_but_bang();
      byte_type b;
      do begin
         b = byte_type'($urandom_range(0, 255));
      end while (b == CHAR_BANG);
      return b;
   endfunction

   function automatic byte_type any_but_marks();
      byte_type b;
      do begin
         b = any_but_bang();
      end while (b == CHAR_EQUALS);
      return b;
   endfunction

   // Called just after a falling edge; returns just after a falling edge.
   task send_byte(byte_type b);
      int unsigned gap;
      gap = steady_send ? 0 : pick_gap();
      repeat (gap) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = b;
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_request(b);
      requests_sent++;
      @(negedge clock);
   endtask

   task send_frame();
      while (frame_q.size() != 0) begin
         send_byte(frame_q.pop_front());
      end
   endtask

   task push_text(string s);
      for (int i = 0; i < s.len(); i++) begin
         frame_q.push_back(byte_type'(s[i]));
      end
   endtask

   task make_frame();
      int unsigned kind;
      int unsigned len;
      logic [15:0] key;
      kind = $urandom_range(0, 99);
      if (kind < 2) begin
         // run past the frame limit, then close whatever is left
         repeat ($urandom_range(FrameLimit, FrameLimit + 6)) frame_q.push_back(any_but_bang());
         frame_q.push_back(CHAR_BANG);
      end else if (kind < 12) begin
         repeat ($urandom_range(1, 12)) frame_q.push_back(byte_type'($urandom_range(0, 255)));
         frame_q.push_back(CHAR_BANG);
      end else begin
         if ($urandom_range(0, 99) < 85) begin
            key = sb.slot_names[$urandom_range(0, SlotCount - 1)];
         end else begin
            key = {any_but_bang(), any_but_bang()};
         end
         frame_q.push_back(key[15:8]);
         frame_q.push_back(key[7:0]);
         if ($urandom_range(0, 9) != 0) begin
            frame_q.push_back(CHAR_EQUALS);
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 12)) frame_q.push_back(any_but_marks());
            frame_q.push_back(CHAR_EQUALS);
         end
         if ($urandom_range(0, 9) < 4) begin
            frame_q.push_back(CHAR_MINUS);
         end
         len = ($urandom_range(0, 9) < 8) ? $urandom_range(4, 8) : $urandom_range(0, 11);
         for (int i = 0; i < len; i++) begin
            if (i == int'(len) - 3) begin
               frame_q.push_back(($urandom_range(0, 9) != 0) ? CHAR_POINT : any_but_marks());
            end else if ($urandom_range(0, 9) != 0) begin
               frame_q.push_back(CHAR_ZERO + byte_type'($urandom_range(0, 9)));
            end else begin
               frame_q.push_back(any_but_marks());
            end
         end
         frame_q.push_back(CHAR_BANG);
      end
   endtask

   // Receiver: random stalls with stretches of steady acceptance.
   initial begin
      rsp_tready = 1'b0;
      recv_hold = 0;
      steady_recv = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_hold > 0) begin
            rsp_tready = 1'b0;
            recv_hold--;
         end else begin
            rsp_tready = 1'b1;
            if (!steady_recv && $urandom_range(0, 3) == 0) begin
               recv_hold = pick_gap();
            end
         end
         if ($urandom_range(0, 199) == 0) begin
            steady_recv = !steady_recv;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata);
      end
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      requests_sent = 0;
      steady_send = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty frame, lone minus, widest negative field, lowest byte codes
      push_text("!");
      push_text("-!");
      push_text("Ot=-");
      repeat (8) frame_q.push_back(8'hFF);
      frame_q.push_back(CHAR_BANG);
      push_text("K1=");
      frame_q.push_back(8'h00);
      frame_q.push_back(8'h00);
      frame_q.push_back(CHAR_POINT);
      frame_q.push_back(8'h00);
      frame_q.push_back(CHAR_BANG);
      send_frame();

      while (requests_sent < RequestTarget + 24) begin
         steady_send = ($urandom_range(0, 9) < 3);
         make_frame();
         send_frame();
      end
      req_tvalid = 1'b0;

      while (sb.pending_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (sb.pending_q.size() != 0) begin
         sb.report($sformatf("%0d responses never arrived", sb.pending_q.size()));
      end
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
